### hw/rtl/ede_pkg.sv
// Package with the shared types and constants of the edit distance engine.
`timescale 1ns / 1ps

package ede_pkg;

  localparam int unsigned MaxLen   = 64;
  localparam int unsigned LenW     = $clog2(MaxLen + 1);
  localparam int unsigned StrAddrW = $clog2(MaxLen);
  localparam int unsigned RowDepth = MaxLen + 1;
  localparam int unsigned RowAddrW = $clog2(RowDepth);
  localparam int unsigned DistW    = 7;
  localparam int unsigned SymW     = 8;

  localparam logic [1:0] CmdAppendA = 2'd0;
  localparam logic [1:0] CmdAppendB = 2'd1;
  localparam logic [1:0] CmdCompute = 2'd2;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [SymW-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             overflow;
    logic             is_compute_result;
  } out_t;

  typedef struct packed {
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
  } job_t;

endpackage

### hw/rtl/ede_ram.sv
// Generic single-port-write, single-port-read memory with a registered read.
`timescale 1ns / 1ps

module ede_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/ede_dp.sv
// Row-by-row walk of the edit distance table over a single-row memory.
`timescale 1ns / 1ps

module ede_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  ede_pkg::job_t                        job_i,
  output logic                                 busy_o,
  output logic [ede_pkg::StrAddrW-1:0]         a_rd_addr_o,
  output logic [ede_pkg::StrAddrW-1:0]         b_rd_addr_o,
  input  logic [ede_pkg::SymW-1:0]             a_data_i,
  input  logic [ede_pkg::SymW-1:0]             b_data_i,
  output logic                                 done_o,
  output logic [ede_pkg::DistW-1:0]            dist_o
);
  import ede_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROW  = 2'd1;
  localparam logic [1:0] S_CELL = 2'd2;

  logic [1:0]          state_q, state_d;
  job_t                job_q, job_d;
  logic [LenW-1:0]     i_q, i_d;
  logic [LenW-1:0]     j_q, j_d;
  logic [DistW-1:0]    diag_q, diag_d;
  logic [DistW-1:0]    left_q, left_d;

  logic [RowAddrW-1:0] row_rd_addr;
  logic [DistW-1:0]    row_rd_data;
  logic                row_we;
  logic [DistW-1:0]    above;
  logic [DistW-1:0]    min_ld;
  logic [DistW-1:0]    min_all;
  logic [DistW-1:0]    cell_val;

  ede_ram #(
    .Width(DistW),
    .Depth(RowDepth)
  ) u_row_ram (
    .clk_i    (clk_i),
    .wr_en_i  (row_we),
    .wr_addr_i(RowAddrW'(j_q)),
    .wr_data_i(cell_val),
    .rd_addr_i(row_rd_addr),
    .rd_data_o(row_rd_data)
  );

  always_comb begin
    if (state_q == S_CELL && j_q < job_q.len_b) begin
      row_rd_addr = RowAddrW'(j_q) + RowAddrW'(1);
    end else begin
      row_rd_addr = RowAddrW'(1);
    end
  end

  assign b_rd_addr_o = StrAddrW'(row_rd_addr - RowAddrW'(1));
  assign a_rd_addr_o = StrAddrW'(i_q - LenW'(1));

  assign above    = (i_q == LenW'(1)) ? DistW'(j_q) : row_rd_data;
  assign min_ld   = (left_q < diag_q) ? left_q : diag_q;
  assign min_all  = (min_ld < above) ? min_ld : above;
  assign cell_val = (a_data_i == b_data_i) ? diag_q : min_all + DistW'(1);
  assign row_we   = (state_q == S_CELL);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    i_d     = i_q;
    j_d     = j_q;
    diag_d  = diag_q;
    left_d  = left_q;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          job_d   = job_i;
          i_d     = LenW'(1);
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        diag_d  = DistW'(i_q - LenW'(1));
        left_d  = DistW'(i_q);
        j_d     = LenW'(1);
        state_d = S_CELL;
      end
      S_CELL: begin
        left_d = cell_val;
        diag_d = above;
        if (j_q == job_q.len_b) begin
          if (i_q == job_q.len_a) begin
            done_o  = 1'b1;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + LenW'(1);
            state_d = S_ROW;
          end
        end else begin
          j_d = j_q + LenW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    i_q    <= i_d;
    j_q    <= j_d;
    diag_q <= diag_d;
    left_q <= left_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign dist_o = cell_val;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("Job started while the table walk is running.");

  a_row_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |-> (j_q != '0 && j_q <= job_q.len_b))
    else $error("Row write outside the columns of string B.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == S_IDLE)
    else $error("Walk did not return to idle after its last cell.");

  a_row_follows_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROW |=> state_q == S_CELL)
    else $error("Row start not followed by a cell step.");

endmodule

### hw/rtl/edit_distance_engine_unit.sv
// Top level of the edit distance engine: intake, string memories and result register.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         in_valid_i / in_ready_o   in_req_i  (cmd, symbol)
//   result    out        out_valid_o / out_ready_i out_rsp_o (distance, overflow, flag)
//
// An append's acknowledgement is registered, so appends can follow one another in
// consecutive cycles while out_ready_i keeps the result slot free. A compute with
// both strings non-empty walks one table cell per cycle through the single read port
// of the row memory, plus a row-start step before each row.
// No request is taken while the walk runs. Reset clears lengths, the drop flag and
// control state; the memories need no clearing pass.
`timescale 1ns / 1ps

module edit_distance_engine_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ede_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ede_pkg::out_t out_rsp_o
);
  import ede_pkg::*;

  logic [LenW-1:0]     len_a_q, len_a_d;
  logic [LenW-1:0]     len_b_q, len_b_d;
  logic                drop_q, drop_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                accept;
  logic                is_append_a;
  logic                is_append_b;
  logic                is_compute;
  logic                a_full;
  logic                b_full;
  logic                wr_a;
  logic                wr_b;
  logic                start;
  logic                busy;
  logic                done;
  logic [DistW-1:0]    walk_dist;
  job_t                job;
  logic [StrAddrW-1:0] a_rd_addr;
  logic [StrAddrW-1:0] b_rd_addr;
  logic [SymW-1:0]     a_data;
  logic [SymW-1:0]     b_data;

  assign in_ready_o  = !busy && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign is_append_a = (in_req_i.cmd == CmdAppendA);
  assign is_append_b = (in_req_i.cmd == CmdAppendB);
  assign is_compute  = (in_req_i.cmd == CmdCompute);
  assign a_full      = (len_a_q == LenW'(MaxLen));
  assign b_full      = (len_b_q == LenW'(MaxLen));
  assign wr_a        = accept && is_append_a && !a_full;
  assign wr_b        = accept && is_append_b && !b_full;
  assign start       = accept && is_compute && len_a_q != '0 && len_b_q != '0;

  assign job.len_a = len_a_q;
  assign job.len_b = len_b_q;

  ede_ram #(
    .Width(SymW),
    .Depth(MaxLen)
  ) u_str_a (
    .clk_i    (clk_i),
    .wr_en_i  (wr_a),
    .wr_addr_i(StrAddrW'(len_a_q)),
    .wr_data_i(in_req_i.symbol),
    .rd_addr_i(a_rd_addr),
    .rd_data_o(a_data)
  );

  ede_ram #(
    .Width(SymW),
    .Depth(MaxLen)
  ) u_str_b (
    .clk_i    (clk_i),
    .wr_en_i  (wr_b),
    .wr_addr_i(StrAddrW'(len_b_q)),
    .wr_data_i(in_req_i.symbol),
    .rd_addr_i(b_rd_addr),
    .rd_data_o(b_data)
  );

  ede_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .job_i      (job),
    .busy_o     (busy),
    .a_rd_addr_o(a_rd_addr),
    .b_rd_addr_o(b_rd_addr),
    .a_data_i   (a_data),
    .b_data_i   (b_data),
    .done_o     (done),
    .dist_o     (walk_dist)
  );

  always_comb begin
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    drop_d      = drop_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (done) begin
      out_d.distance          = walk_dist;
      out_d.overflow          = drop_q;
      out_d.is_compute_result = 1'b1;
      out_valid_d             = 1'b1;
      len_a_d                 = '0;
      len_b_d                 = '0;
      drop_d                  = 1'b0;
    end else if (accept && (is_append_a || is_append_b)) begin
      if (wr_a) begin
        len_a_d = len_a_q + LenW'(1);
      end
      if (wr_b) begin
        len_b_d = len_b_q + LenW'(1);
      end
      drop_d = drop_q || (is_append_a && a_full) || (is_append_b && b_full);
      out_d.distance          = '0;
      out_d.overflow          = drop_d;
      out_d.is_compute_result = 1'b0;
      out_valid_d             = 1'b1;
    end else if (accept && is_compute && !start) begin
      out_d.distance          = (len_a_q == '0) ? DistW'(len_b_q) : DistW'(len_a_q);
      out_d.overflow          = drop_q;
      out_d.is_compute_result = 1'b1;
      out_valid_d             = 1'b1;
      len_a_d                 = '0;
      len_b_d                 = '0;
      drop_d                  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q     <= '0;
      len_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || out_ready_i))
    else $error("Compute result would overwrite a pending result.");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !accept)
    else $error("Request taken while the table walk is running.");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= LenW'(MaxLen)) && (len_b_q <= LenW'(MaxLen)))
    else $error("String length beyond its memory depth.");

endmodule
